[sv/lvs_pkg.sv]
// Package: shared constants and types for the Legendre value and slope unit.
`timescale 1ns / 1ps

package lvs_pkg;

    // Fixed-point format of the point and of both results
    localparam int FRAC_BITS = 30;
    localparam int ORDER_W   = 3;
    localparam int POINT_W   = 32;
    localparam int RES_W     = 40;
    // Square of a 32-bit point after the fraction shift
    localparam int SQ_W      = 34;
    // Cube and fourth power after the fraction shift
    localparam int CUBE_W    = 35;
    localparam int QUAD_W    = 36;
    // Sums of scaled powers before the final shift
    localparam int WIDE_W    = 44;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [RES_W-1:0]  t_res;

    // Polynomial order codes
    localparam logic [ORDER_W-1:0] ORD_0 = 3'd0;
    localparam logic [ORDER_W-1:0] ORD_1 = 3'd1;
    localparam logic [ORDER_W-1:0] ORD_2 = 3'd2;
    localparam logic [ORDER_W-1:0] ORD_3 = 3'd3;
    localparam logic [ORDER_W-1:0] ORD_4 = 3'd4;

    // Final arithmetic shift applied to a sum
    typedef enum logic [1:0] {
        SHR_0,
        SHR_1,
        SHR_3
    } t_shr;

    localparam t_wide ONE_W   = t_wide'(64'sd1 <<< FRAC_BITS);
    localparam t_res  ONE_RES = t_res'(64'sd1 <<< FRAC_BITS);

endpackage

[sv/legendre_value_and_slope_unit.sv]
// Top level: four-stage pipeline evaluating Legendre P_n(x) and P_n'(x), n = 0..4.
`timescale 1ns / 1ps

// Takes one beat per clock (order n, point x in signed Q1.30) and returns
// P_n(x) and P_n'(x) as signed 40-bit Q9.30 values, saturated; orders 5 to 7
// return zero for both. A new beat may enter every cycle when the output side
// does not stall.
// Stage 1 forms x^2 with a 32x32-bit multiplier, stage 2 forms x^3 and x^4
// with a 34x32-bit and a 34x34-bit multiplier, stage 3 adds the scaled powers
// for the chosen order and stage 4 applies the final shift and saturation.
// Every product is truncated toward minus infinity. Each stage holds its beat
// on a stall and frees as soon as the next one moves, so bubbles are squeezed
// out.
module legendre_value_and_slope_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [2:0] order, [34:3] point, [39:35] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // [39:0] poly_value, [79:40] poly_slope
);

    localparam int FB = lvs_pkg::FRAC_BITS;

    // Stage valid bits and per-stage ready
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1 registers
    logic [lvs_pkg::ORDER_W-1:0]       r1_ord;
    logic signed [lvs_pkg::POINT_W-1:0] r1_x;
    logic signed [lvs_pkg::SQ_W-1:0]    r1_x2;

    // Stage 2 registers
    logic [lvs_pkg::ORDER_W-1:0]        r2_ord;
    logic signed [lvs_pkg::POINT_W-1:0] r2_x;
    logic signed [lvs_pkg::SQ_W-1:0]    r2_x2;
    logic signed [lvs_pkg::CUBE_W-1:0]  r2_x3;
    logic signed [lvs_pkg::QUAD_W-1:0]  r2_x4;

    // Stage 3 registers
    logic [lvs_pkg::ORDER_W-1:0] r3_ord;
    lvs_pkg::t_wide              r3_psum, r3_dsum;
    lvs_pkg::t_shr               r3_pshr, r3_dshr;

    // Stage 4 (output) registers
    logic [lvs_pkg::ORDER_W-1:0] r4_ord;
    lvs_pkg::t_res               r4_val, r4_slp;

    // Next values
    logic [lvs_pkg::ORDER_W-1:0]        in_ord;
    logic signed [lvs_pkg::POINT_W-1:0] in_x;
    logic signed [63:0]                 n_sq_full;
    logic signed [lvs_pkg::SQ_W-1:0]    n_x2;
    logic signed [65:0]                 n_cube_full;
    logic signed [67:0]                 n_quad_full;
    logic signed [lvs_pkg::CUBE_W-1:0]  n_x3;
    logic signed [lvs_pkg::QUAD_W-1:0]  n_x4;
    lvs_pkg::t_wide                     x_w, x2_w, x3_w, x4_w;
    lvs_pkg::t_wide                     n_psum, n_dsum;
    lvs_pkg::t_shr                      n_pshr, n_dshr;
    lvs_pkg::t_wide                     p_shifted, d_shifted;
    lvs_pkg::t_res                      n_val, n_slp;

    // Handshake: a stage takes a beat when it is empty or its content moves on
    assign rdy4       = !r_v4 || i_m_tready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_s_tready = rdy1;
    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {r4_slp, r4_val};

    // Input unpacking
    assign in_ord = i_s_tdata[2:0];
    assign in_x   = signed'(i_s_tdata[34:3]);

    // Stage 1 math: x^2 with floor shift
    assign n_sq_full = in_x * in_x;
    assign n_x2      = n_sq_full[FB+lvs_pkg::SQ_W-1:FB];

    // Stage 2 math: x^3 and x^4 with floor shift
    assign n_cube_full = r1_x2 * r1_x;
    assign n_quad_full = r1_x2 * r1_x2;
    assign n_x3        = n_cube_full[FB+lvs_pkg::CUBE_W-1:FB];
    assign n_x4        = n_quad_full[FB+lvs_pkg::QUAD_W-1:FB];

    // Stage 3 math: scaled sums per order
    assign x_w  = lvs_pkg::t_wide'(r2_x);
    assign x2_w = lvs_pkg::t_wide'(r2_x2);
    assign x3_w = lvs_pkg::t_wide'(r2_x3);
    assign x4_w = lvs_pkg::t_wide'(r2_x4);

    always_comb begin
        n_psum = '0;
        n_dsum = '0;
        n_pshr = lvs_pkg::SHR_0;
        n_dshr = lvs_pkg::SHR_0;
        case (r2_ord)
            lvs_pkg::ORD_0: begin
                n_psum = lvs_pkg::ONE_W;
            end
            lvs_pkg::ORD_1: begin
                n_psum = x_w;
                n_dsum = lvs_pkg::ONE_W;
            end
            lvs_pkg::ORD_2: begin
                // (3 x^2 - 1) / 2, slope 3 x
                n_psum = (x2_w <<< 1) + x2_w - lvs_pkg::ONE_W;
                n_pshr = lvs_pkg::SHR_1;
                n_dsum = (x_w <<< 1) + x_w;
            end
            lvs_pkg::ORD_3: begin
                // (5 x^3 - 3 x) / 2, slope (15 x^2 - 3) / 2
                n_psum = (x3_w <<< 2) + x3_w - ((x_w <<< 1) + x_w);
                n_pshr = lvs_pkg::SHR_1;
                n_dsum = (x2_w <<< 4) - x2_w
                       - ((lvs_pkg::ONE_W <<< 1) + lvs_pkg::ONE_W);
                n_dshr = lvs_pkg::SHR_1;
            end
            lvs_pkg::ORD_4: begin
                // (35 x^4 - 30 x^2 + 3) / 8, slope (35 x^3 - 15 x) / 2
                n_psum = (x4_w <<< 5) + (x4_w <<< 1) + x4_w
                       - ((x2_w <<< 5) - (x2_w <<< 1))
                       + ((lvs_pkg::ONE_W <<< 1) + lvs_pkg::ONE_W);
                n_pshr = lvs_pkg::SHR_3;
                n_dsum = (x3_w <<< 5) + (x3_w <<< 1) + x3_w
                       - ((x_w <<< 4) - x_w);
                n_dshr = lvs_pkg::SHR_1;
            end
            default: begin
                n_psum = '0;
                n_dsum = '0;
            end
        endcase
    end

    // Stage 4 math: final shift, then clamp to 40 bits
    function automatic lvs_pkg::t_wide shift_sum(lvs_pkg::t_wide v, lvs_pkg::t_shr s);
        lvs_pkg::t_wide r;
        case (s)
            lvs_pkg::SHR_1: r = v >>> 1;
            lvs_pkg::SHR_3: r = v >>> 3;
            default:        r = v;
        endcase
        return r;
    endfunction

    function automatic lvs_pkg::t_res clamp_res(lvs_pkg::t_wide v);
        lvs_pkg::t_res r;
        if (!v[lvs_pkg::WIDE_W-1] && (|v[lvs_pkg::WIDE_W-2:lvs_pkg::RES_W-1])) begin
            r = {1'b0, {(lvs_pkg::RES_W-1){1'b1}}};
        end else if (v[lvs_pkg::WIDE_W-1] && !(&v[lvs_pkg::WIDE_W-2:lvs_pkg::RES_W-1])) begin
            r = {1'b1, {(lvs_pkg::RES_W-1){1'b0}}};
        end else begin
            r = v[lvs_pkg::RES_W-1:0];
        end
        return r;
    endfunction

    assign p_shifted = shift_sum(r3_psum, r3_pshr);
    assign d_shifted = shift_sum(r3_dsum, r3_dshr);
    assign n_val     = clamp_res(p_shifted);
    assign n_slp     = clamp_res(d_shifted);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ord <= in_ord;
            r1_x   <= in_x;
            r1_x2  <= n_x2;
        end
        if (rdy2) begin
            r2_ord <= r1_ord;
            r2_x   <= r1_x;
            r2_x2  <= r1_x2;
            r2_x3  <= n_x3;
            r2_x4  <= n_x4;
        end
        if (rdy3) begin
            r3_ord  <= r2_ord;
            r3_psum <= n_psum;
            r3_dsum <= n_dsum;
            r3_pshr <= n_pshr;
            r3_dshr <= n_dshr;
        end
        if (rdy4) begin
            r4_ord <= r3_ord;
            r4_val <= n_val;
            r4_slp <= n_slp;
        end
    end

    // The square of any point is never negative
    a_square_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> !r1_x2[lvs_pkg::SQ_W-1])
        else $error("x^2 stage holds a negative value");

    // Order zero gives one and a flat slope
    a_order0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r4_ord == lvs_pkg::ORD_0) |->
            (r4_val == lvs_pkg::ONE_RES && r4_slp == '0))
        else $error("order zero result is not (1, 0)");

    // Orders above four give zero for both results
    a_high_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r4_ord > lvs_pkg::ORD_4) |-> (r4_val == '0 && r4_slp == '0))
        else $error("unsupported order gave a nonzero result");

    // A stalled output stage keeps its beat and the stage behind it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_m_tready && r_v3) |=> (r_v4 && r_v3))
        else $error("pipeline lost a beat under stall");

endmodule

[tb/legendre_value_and_slope_unit_tb.sv]
// Self-checking testbench for the Legendre value and slope unit, with an in-bench predictor.
`timescale 1ns / 1ps

module legendre_value_and_slope_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BEATS    = 470;

    typedef logic signed [127:0] t_big;

    typedef struct {
        lvs_pkg::t_res value;
        lvs_pkg::t_res slope;
    } t_value_slope;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;    // [2:0] order, [34:3] point, [39:35] zero
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;          // [39:0] poly_value, [79:40] poly_slope

    t_value_slope pending_value_slope_q[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    legendre_value_and_slope_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Clamp a wide result to the signed 40-bit output range
    function automatic lvs_pkg::t_res clamp_to_res(t_big v);
        t_big hi_lim;
        t_big lo_lim;
        hi_lim = (t_big'(1) <<< (lvs_pkg::RES_W - 1)) - 1;
        lo_lim = -(t_big'(1) <<< (lvs_pkg::RES_W - 1));
        if (v > hi_lim) begin
            return lvs_pkg::t_res'(hi_lim);
        end
        if (v < lo_lim) begin
            return lvs_pkg::t_res'(lo_lim);
        end
        return lvs_pkg::t_res'(v);
    endfunction

    // P_n(x) and P_n'(x); products floor back to FRAC_BITS, all sums held wide
    function automatic t_value_slope legendre_value_slope(
        logic [lvs_pkg::ORDER_W-1:0] ord,
        logic [lvs_pkg::POINT_W-1:0] pt
    );
        t_big x;
        t_big x2;
        t_big x3;
        t_big x4;
        t_big one;
        t_big p;
        t_big d;
        t_value_slope r;
        x   = $signed(pt);
        one = t_big'(1) <<< lvs_pkg::FRAC_BITS;
        x2  = (x * x) >>> lvs_pkg::FRAC_BITS;
        x3  = (x2 * x) >>> lvs_pkg::FRAC_BITS;
        x4  = (x2 * x2) >>> lvs_pkg::FRAC_BITS;
        p   = 0;
        d   = 0;
        case (ord)
            lvs_pkg::ORD_0: begin
                p = one;
            end
            lvs_pkg::ORD_1: begin
                p = x;
                d = one;
            end
            lvs_pkg::ORD_2: begin
                p = (3 * x2 - one) >>> 1;
                d = 3 * x;
            end
            lvs_pkg::ORD_3: begin
                p = (5 * x3 - 3 * x) >>> 1;
                d = (15 * x2 - 3 * one) >>> 1;
            end
            lvs_pkg::ORD_4: begin
                p = (35 * x4 - 30 * x2 + 3 * one) >>> 3;
                d = (35 * x3 - 15 * x) >>> 1;
            end
            default: begin
                // orders five to seven give zero
                p = 0;
                d = 0;
            end
        endcase
        r.value = clamp_to_res(p);
        r.slope = clamp_to_res(d);
        return r;
    endfunction

    // Output side stalls at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Record accepted input beats, check accepted output beats
    always @(posedge i_clk) begin
        t_value_slope want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_value_slope_q.size() == 0) begin
                $display("%0t: unexpected output beat value=%h slope=%h",
                         $time, o_m_tdata[39:0], o_m_tdata[79:40]);
                mismatch_count++;
            end else begin
                want = pending_value_slope_q.pop_front();
                if (o_m_tdata[39:0] !== want.value) begin
                    $display("%0t: poly_value mismatch expected=%h actual=%h",
                             $time, want.value, o_m_tdata[39:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[79:40] !== want.slope) begin
                    $display("%0t: poly_slope mismatch expected=%h actual=%h",
                             $time, want.slope, o_m_tdata[79:40]);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pending_value_slope_q.push_back(
                legendre_value_slope(i_s_tdata[2:0], i_s_tdata[34:3]));
        end
    end

    // Watchdog on cycles with no beat moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog expired", $time);
        $display("Regression FAIL");
        $finish;
    end

    // Send one beat after a random gap; called and left at a falling edge
    task automatic send_point(logic [lvs_pkg::ORDER_W-1:0] ord,
                              logic [lvs_pkg::POINT_W-1:0] pt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, pt, ord};
        do begin
            @(posedge i_clk);
        end while (!(i_s_tvalid && o_s_tready));
        @(negedge i_clk);
    endtask

    // Hold off new beats until every pending result is back
    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (pending_value_slope_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Mostly in-range points and evaluated orders, with some full-range noise
    task automatic send_random_points(int count);
        logic [lvs_pkg::ORDER_W-1:0] ord;
        logic [lvs_pkg::POINT_W-1:0] pt;
        int                          pick;
        for (int i = 0; i < count; i++) begin
            ord  = ($urandom_range(99) < 80) ? lvs_pkg::ORDER_W'($urandom_range(4))
                                              : lvs_pkg::ORDER_W'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 65) begin
                pt = lvs_pkg::POINT_W'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
            end else if (pick < 85) begin
                pt = $urandom;
            end else if (pick < 93) begin
                pt = lvs_pkg::POINT_W'($urandom_range(64)) - 32'd32;
            end else begin
                case ($urandom_range(3))
                    0: pt = 32'h7FFF_FFFF - $urandom_range(15);
                    1: pt = 32'h8000_0000 + $urandom_range(15);
                    2: pt = 32'h4000_0000 + $urandom_range(8) - 32'd4;
                    default: pt = 32'hC000_0000 + $urandom_range(8) - 32'd4;
                endcase
            end
            send_point(ord, pt);
        end
    endtask

    // Every order at the point extremes, and each notable value of x at one order
    task automatic test_directed_points();
        logic [lvs_pkg::POINT_W-1:0] notable [8];
        notable = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h2000_0000,
                    32'hE000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 32'h6000_0000};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 24; i++) begin
            case (i / 8)
                0: send_point(lvs_pkg::ORDER_W'(i % 8), 32'h7FFF_FFFF);
                1: send_point(lvs_pkg::ORDER_W'(i % 8), 32'h8000_0000);
                default: send_point(lvs_pkg::ORDER_W'(i % 8), notable[i % 8]);
            endcase
        end
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_points(PHASE_BEATS);
        wait_all_results();
    endtask

    task automatic test_sparse_input();
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        send_random_points(PHASE_BEATS);
        wait_all_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        send_random_points(PHASE_BEATS);
        wait_all_results();
    endtask

    task automatic test_mixed_gaps();
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        send_random_points(PHASE_BEATS);
        wait_all_results();
    endtask

    // Reset, run the tests, drain and report
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_points();
        test_back_to_back();
        test_sparse_input();
        test_output_backpressure();
        test_mixed_gaps();
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_value_slope_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_value_slope_q.size());
        end
        if (mismatch_count == 0 && pending_value_slope_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
